@@ hw/rtl/lpm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lpm_pkg: shared types for the IPv4 longest-prefix-match forwarding engine
// Result status codes, front-to-back command beat and result beat.
// ----------------------------------------------------------------------------
package lpm_pkg;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_FORWARD    = 3'd0,
    ST_LOCAL      = 3'd1,
    ST_TTL_DROP   = 3'd2,
    ST_NO_ROUTE   = 3'd3,
    ST_ROUTE_ADD  = 3'd4,
    ST_TABLE_FULL = 3'd5
  } status_e;

  // Work kinds handed from the front part to the back part.
  typedef enum logic [1:0] {
    CMD_RESULT = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_op_e;

  localparam int unsigned AddrBits = 32;
  localparam logic [5:0]  MaxLen   = 6'd32;
  localparam logic [3:0]  MinIhl   = 4'd5;

  typedef struct packed {
    cmd_op_e              op;
    status_e              status;
    logic [AddrBits-1:0]  dest;
    logic [5:0]           len;
    logic [31:0]          hop;
    logic [7:0]           ttl;
    logic [15:0]          csum;
  } cmd_t;

  typedef struct packed {
    status_e      status;
    logic [31:0]  next_hop;
    logic [7:0]   new_ttl;
    logic [15:0]  new_checksum;
  } result_t;

endpackage
`default_nettype wire

@@ hw/rtl/ipv4_lpm_forward_engine_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_lpm_forward_engine_top: IPv4 forwarding engine with trie route table
// Front part classifies header words and route adds, a command queue feeds
// the trie engine, and a result queue holds finished beats.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Payload
//  input     push / full           req_type_i, header_word_i, route_dest_i,
//                                  route_masklen_i, route_nexthop_i
//  result    empty / pop           status_o, next_hop_o, new_ttl_o,
//                                  new_checksum_o
//  config    cfg_we_i              cfg_wdata_i (own address)
//
//  A header word that is not the last of its packet issues no command.
//  A lookup or route add walks the trie in the engine, up to 32 levels deep;
//  each level through an existing node is one memory read.
//  Reset leaves the root empty and the pool at one used node; no clearing pass.
//  Two-entry queues on both sides of the engine let input and output stall
//  independently.
module ipv4_lpm_forward_engine_top #(
  parameter int unsigned NODE_COUNT = 1024
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push,
  output logic              full,
  input  wire logic         req_type_i,
  input  wire logic [31:0]  header_word_i,
  input  wire logic [31:0]  route_dest_i,
  input  wire logic [5:0]   route_masklen_i,
  input  wire logic [31:0]  route_nexthop_i,
  output logic              empty,
  input  wire logic         pop,
  output logic [2:0]        status_o,
  output logic [31:0]       next_hop_o,
  output logic [7:0]        new_ttl_o,
  output logic [15:0]       new_checksum_o,
  input  wire logic         cfg_we_i,
  input  wire logic [31:0]  cfg_wdata_i
);

  logic [31:0]       own_address_q;
  logic              accept;
  logic              cmd_push, cmd_pop, cmd_empty;
  lpm_pkg::cmd_t     cmd_in, cmd_out;
  logic              res_push, res_full;
  lpm_pkg::result_t  res_in, res_out;

  assign accept = push && !full;

  // Own address register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_address_q <= 32'd0;
    end else if (cfg_we_i) begin
      own_address_q <= cfg_wdata_i;
    end
  end

  lpm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .req_type_i     (req_type_i),
    .header_word_i  (header_word_i),
    .route_dest_i   (route_dest_i),
    .route_masklen_i(route_masklen_i),
    .route_nexthop_i(route_nexthop_i),
    .own_address_i  (own_address_q),
    .cmd_push_o     (cmd_push),
    .cmd_o          (cmd_in)
  );

  lpm_queue #(.Width($bits(lpm_pkg::cmd_t))) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .full_o (full),
    .pop_i  (cmd_pop),
    .data_o (cmd_out),
    .empty_o(cmd_empty)
  );

  lpm_back #(.NODE_COUNT(NODE_COUNT)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  lpm_queue #(.Width($bits(lpm_pkg::result_t))) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_out),
    .empty_o(empty)
  );

  assign status_o       = res_out.status;
  assign next_hop_o     = res_out.next_hop;
  assign new_ttl_o      = res_out.new_ttl;
  assign new_checksum_o = res_out.new_checksum;

endmodule
`default_nettype wire

@@ hw/rtl/lpm_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lpm_queue: two-entry first-in first-out buffer
// Decouples producer and consumer; full and empty are registered views.
// ----------------------------------------------------------------------------
module lpm_queue #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  logic [Width-1:0] slot_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and occupancy tracking.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      if (do_push && !do_pop)      count_q <= count_q + 2'd1;
      else if (do_pop && !do_push) count_q <= count_q - 2'd1;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= data_i;
  end

endmodule
`default_nettype wire

@@ hw/rtl/lpm_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lpm_front: header intake and classification
// Gathers header words, keeps the running checksum and decides local, TTL
// discard or lookup; route adds pass straight through as commands.
// ----------------------------------------------------------------------------
module lpm_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         accept_i,
  input  wire logic         req_type_i,
  input  wire logic [31:0]  header_word_i,
  input  wire logic [31:0]  route_dest_i,
  input  wire logic [5:0]   route_masklen_i,
  input  wire logic [31:0]  route_nexthop_i,
  input  wire logic [31:0]  own_address_i,
  output logic              cmd_push_o,
  output lpm_pkg::cmd_t     cmd_o
);

  logic [15:0] sum_q, sum_d;
  logic [3:0]  widx_q, widx_d;
  logic [3:0]  hwords_q, hwords_d;
  logic [31:0] dest_q, dest_d;
  logic [7:0]  ttl_q, ttl_d;
  logic [15:0] sum_mid;
  logic        last_word;
  logic [7:0]  ttl_dec;

  // Ones-complement add of two 16-bit values with end-around carry.
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] f;
    s = {1'b0, a} + {1'b0, b};
    f = {1'b0, s[15:0]} + {16'd0, s[16]};
    return f[15:0];
  endfunction

  // Header word bookkeeping.
  always_comb begin
    hwords_d = hwords_q;
    dest_d   = dest_q;
    ttl_d    = ttl_q;
    if (widx_q == 4'd0) begin
      hwords_d = (header_word_i[27:24] < lpm_pkg::MinIhl) ? lpm_pkg::MinIhl
                                                           : header_word_i[27:24];
    end
    if (widx_q == 4'd2) ttl_d = header_word_i[31:24];
    if (widx_q == 4'd4) dest_d = header_word_i;
    ttl_dec = ttl_d - 8'd1;
    if (widx_q == 4'd2) begin
      sum_mid = oc_add(sum_q, {ttl_dec, header_word_i[23:16]});
    end else begin
      sum_mid = oc_add(oc_add(sum_q, header_word_i[31:16]), header_word_i[15:0]);
    end
    last_word = ({1'b0, widx_q} + 5'd1) >= {1'b0, hwords_d};
    sum_d     = last_word ? 16'd0 : sum_mid;
    widx_d    = last_word ? 4'd0 : widx_q + 4'd1;
  end

  // Command for the back part.
  always_comb begin
    cmd_o.op     = lpm_pkg::CMD_RESULT;
    cmd_o.status = lpm_pkg::ST_NO_ROUTE;
    cmd_o.dest   = route_dest_i;
    cmd_o.len    = route_masklen_i;
    cmd_o.hop    = route_nexthop_i;
    cmd_o.ttl    = ttl_dec;
    cmd_o.csum   = ~sum_mid;
    cmd_push_o   = 1'b0;
    if (accept_i) begin
      if (req_type_i) begin
        cmd_o.op   = lpm_pkg::CMD_ADD;
        cmd_push_o = 1'b1;
      end else if (last_word) begin
        cmd_push_o = 1'b1;
        cmd_o.dest = dest_d;
        cmd_o.len  = lpm_pkg::MaxLen;
        if (dest_d == own_address_i) begin
          cmd_o.status = lpm_pkg::ST_LOCAL;
        end else if (ttl_d == 8'd0) begin
          cmd_o.status = lpm_pkg::ST_TTL_DROP;
        end else begin
          cmd_o.op = lpm_pkg::CMD_LOOKUP;
        end
      end
    end
  end

  // Streaming state; route adds leave it alone.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= 16'd0;
      widx_q   <= 4'd0;
      hwords_q <= lpm_pkg::MinIhl;
      dest_q   <= 32'd0;
      ttl_q    <= 8'd0;
    end else if (accept_i && !req_type_i) begin
      sum_q    <= sum_d;
      widx_q   <= widx_d;
      hwords_q <= hwords_d;
      dest_q   <= dest_d;
      ttl_q    <= ttl_d;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/lpm_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lpm_back: binary trie engine
// Walks the node memory one level at a time for route inserts and
// longest-prefix lookups; the root node lives in flip-flops.
// ----------------------------------------------------------------------------
module lpm_back #(
  parameter int unsigned NODE_COUNT = 1024
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_empty_i,
  input  wire lpm_pkg::cmd_t  cmd_i,
  output logic                cmd_pop_o,
  input  wire logic           res_full_i,
  output logic                res_push_o,
  output lpm_pkg::result_t    res_o
);

  localparam int unsigned IW = $clog2(NODE_COUNT);
  localparam logic [IW:0] PoolLimit = (IW+1)'(NODE_COUNT);

  typedef struct packed {
    logic [IW-1:0] kid1;
    logic [IW-1:0] kid0;
    logic          mark;
    logic [31:0]   hop;
  } node_t;

  typedef enum logic [2:0] {
    B_IDLE, B_STEP, B_WAIT, B_ALLOC, B_DONE
  } state_e;

  state_e             state_q, state_d;
  lpm_pkg::cmd_op_e   op_q, op_d;
  lpm_pkg::status_e   status_q, status_d;
  logic [31:0]        dest_q, dest_d;
  logic [5:0]         len_q, len_d;
  logic [31:0]        hop_q, hop_d;
  logic [7:0]         ttl_q, ttl_d;
  logic [15:0]        csum_q, csum_d;
  logic [5:0]         lvl_q, lvl_d;
  logic [IW-1:0]      cur_idx_q, cur_idx_d;
  node_t              cur_node_q, cur_node_d;
  node_t              root_q, root_d;
  logic               found_q, found_d;
  logic [31:0]        match_q, match_d;
  logic [IW:0]        used_q, used_d;

  node_t              mem_q [NODE_COUNT];
  node_t              rd_data_q;
  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  node_t              wr_data;

  logic               bit_sel;
  logic [IW-1:0]      next_idx;

  // Walk sequencer.
  always_comb begin
    bit_sel    = dest_q[5'd31 - lvl_q[4:0]];
    next_idx   = bit_sel ? cur_node_q.kid1 : cur_node_q.kid0;
    state_d    = state_q;
    op_d       = op_q;
    status_d   = status_q;
    dest_d     = dest_q;
    len_d      = len_q;
    hop_d      = hop_q;
    ttl_d      = ttl_q;
    csum_d     = csum_q;
    lvl_d      = lvl_q;
    cur_idx_d  = cur_idx_q;
    cur_node_d = cur_node_q;
    root_d     = root_q;
    found_d    = found_q;
    match_d    = match_q;
    used_d     = used_q;
    rd_en      = 1'b0;
    rd_addr    = next_idx;
    wr_en      = 1'b0;
    wr_addr    = cur_idx_q;
    wr_data    = cur_node_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;

    res_o.status       = status_q;
    res_o.next_hop     = 32'd0;
    res_o.new_ttl      = 8'd0;
    res_o.new_checksum = 16'd0;
    if (status_q == lpm_pkg::ST_FORWARD) begin
      res_o.next_hop     = match_q;
      res_o.new_ttl      = ttl_q;
      res_o.new_checksum = csum_q;
    end

    unique case (state_q)
      B_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o  = 1'b1;
          op_d       = cmd_i.op;
          status_d   = cmd_i.status;
          dest_d     = cmd_i.dest;
          len_d      = (cmd_i.len > lpm_pkg::MaxLen) ? lpm_pkg::MaxLen : cmd_i.len;
          hop_d      = cmd_i.hop;
          ttl_d      = cmd_i.ttl;
          csum_d     = cmd_i.csum;
          lvl_d      = 6'd0;
          cur_idx_d  = '0;
          cur_node_d = root_q;
          found_d    = root_q.mark;
          match_d    = root_q.hop;
          state_d    = (cmd_i.op == lpm_pkg::CMD_RESULT) ? B_DONE : B_STEP;
        end
      end
      B_STEP: begin
        if (lvl_q == len_q) begin
          // Prefix fully walked: mark the route, or end the lookup.
          if (op_q == lpm_pkg::CMD_ADD) begin
            wr_en        = 1'b1;
            wr_data.mark = 1'b1;
            wr_data.hop  = hop_q;
            status_d     = lpm_pkg::ST_ROUTE_ADD;
          end else begin
            status_d = found_q ? lpm_pkg::ST_FORWARD : lpm_pkg::ST_NO_ROUTE;
          end
          state_d = B_DONE;
        end else if (next_idx != '0) begin
          rd_en     = 1'b1;
          cur_idx_d = next_idx;
          state_d   = B_WAIT;
        end else if (op_q != lpm_pkg::CMD_ADD) begin
          status_d = found_q ? lpm_pkg::ST_FORWARD : lpm_pkg::ST_NO_ROUTE;
          state_d  = B_DONE;
        end else if (used_q == PoolLimit) begin
          status_d = lpm_pkg::ST_TABLE_FULL;
          state_d  = B_DONE;
        end else begin
          // Link a fresh child into the current node.
          wr_en = 1'b1;
          if (bit_sel) wr_data.kid1 = used_q[IW-1:0];
          else         wr_data.kid0 = used_q[IW-1:0];
          state_d = B_ALLOC;
        end
      end
      B_WAIT: begin
        cur_node_d = rd_data_q;
        lvl_d      = lvl_q + 6'd1;
        if (rd_data_q.mark) begin
          found_d = 1'b1;
          match_d = rd_data_q.hop;
        end
        state_d = B_STEP;
      end
      B_ALLOC: begin
        // Clear the newly taken node and descend into it.
        wr_en      = 1'b1;
        wr_addr    = used_q[IW-1:0];
        wr_data    = '0;
        cur_idx_d  = used_q[IW-1:0];
        cur_node_d = '0;
        used_d     = used_q + (IW+1)'(1);
        lvl_d      = lvl_q + 6'd1;
        state_d    = B_STEP;
      end
      B_DONE: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase

    if (wr_en && (wr_addr == '0)) root_d = wr_data;
  end

  // State and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_IDLE;
      op_q       <= lpm_pkg::CMD_RESULT;
      status_q   <= lpm_pkg::ST_NO_ROUTE;
      dest_q     <= 32'd0;
      len_q      <= 6'd0;
      hop_q      <= 32'd0;
      ttl_q      <= 8'd0;
      csum_q     <= 16'd0;
      lvl_q      <= 6'd0;
      cur_idx_q  <= '0;
      cur_node_q <= '0;
      root_q     <= '0;
      found_q    <= 1'b0;
      match_q    <= 32'd0;
      used_q     <= (IW+1)'(1);
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      status_q   <= status_d;
      dest_q     <= dest_d;
      len_q      <= len_d;
      hop_q      <= hop_d;
      ttl_q      <= ttl_d;
      csum_q     <= csum_d;
      lvl_q      <= lvl_d;
      cur_idx_q  <= cur_idx_d;
      cur_node_q <= cur_node_d;
      root_q     <= root_d;
      found_q    <= found_d;
      match_q    <= match_d;
      used_q     <= used_d;
    end
  end

  // Node memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en && (wr_addr != '0)) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= mem_q[rd_addr];
  end

endmodule
`default_nettype wire

@@ hw/rtl/lpm_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lpm_checker: port-level checks for the forwarding engine
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module lpm_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         empty,
  input wire logic         pop,
  input wire logic [2:0]   status_o,
  input wire logic [31:0]  next_hop_o,
  input wire logic [7:0]   new_ttl_o,
  input wire logic [15:0]  new_checksum_o
);

  // Only defined status codes leave the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> status_o <= lpm_pkg::ST_TABLE_FULL)
    else $error("undefined status code");

  // Results other than forward carry zero payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != lpm_pkg::ST_FORWARD) |->
      (next_hop_o == 32'd0 && new_ttl_o == 8'd0 && new_checksum_o == 16'd0))
    else $error("non-forward result with payload");

  // A forwarded packet had a nonzero TTL, so the new TTL never wraps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == lpm_pkg::ST_FORWARD) |-> new_ttl_o != 8'hFF)
    else $error("forwarded TTL wrapped");

  // A waiting result holds until it is popped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(status_o) && $stable(next_hop_o)))
    else $error("waiting result changed");

endmodule

bind ipv4_lpm_forward_engine_top lpm_checker u_lpm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .status_o      (status_o),
  .next_hop_o    (next_hop_o),
  .new_ttl_o     (new_ttl_o),
  .new_checksum_o(new_checksum_o)
);
`default_nettype wire

@@ tb/tb_ipv4_lpm_forward_engine_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ipv4_lpm_forward_engine_top: self-checking bench for the LPM forward engine
// Streams route adds and IPv4 header words with random bursts and gaps,
// predicts every result beat with a trie and checksum model of its own, and
// compares each popped beat field by field while the result side stalls.
// ----------------------------------------------------------------------------
module tb_ipv4_lpm_forward_engine_top;

  localparam int unsigned Nodes      = 1024;
  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned DrainWait  = 100;
  localparam bit          ReqHeader  = 1'b0;
  localparam bit          ReqRoute   = 1'b1;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic        req_type_i;
  logic [31:0] header_word_i;
  logic [31:0] route_dest_i;
  logic [5:0]  route_masklen_i;
  logic [31:0] route_nexthop_i;
  logic        empty;
  logic        pop;
  logic [2:0]  status_o;
  logic [31:0] next_hop_o;
  logic [7:0]  new_ttl_o;
  logic [15:0] new_checksum_o;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  ipv4_lpm_forward_engine_top #(.NODE_COUNT(Nodes)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .req_type_i(req_type_i), .header_word_i(header_word_i),
    .route_dest_i(route_dest_i), .route_masklen_i(route_masklen_i),
    .route_nexthop_i(route_nexthop_i), .empty(empty), .pop(pop),
    .status_o(status_o), .next_hop_o(next_hop_o), .new_ttl_o(new_ttl_o),
    .new_checksum_o(new_checksum_o), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  // Route table model and header streaming state.
  int unsigned trie_kid [Nodes][2];
  bit          trie_mark [Nodes];
  logic [31:0] trie_hop [Nodes];
  int unsigned pool_used;
  logic [31:0] my_addr;
  logic [16:0] csum_acc;
  int unsigned hdr_pos;
  int unsigned hdr_len;
  logic [31:0] pkt_dest;
  logic [7:0]  pkt_ttl;

  lpm_pkg::result_t fwd_results_q[$];
  logic [31:0] known_dests[$];
  int unsigned known_lens[$];

  int unsigned err_count;
  int unsigned beats_sent;
  int unsigned beats_checked;
  int unsigned forwards_seen;
  int unsigned full_seen;
  int unsigned cycle_count;
  int unsigned burst_left;
  bit          sender_steady;
  bit          hold_req;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [16:0] fold17(logic [31:0] s);
    return {1'b0, s[15:0]} + {1'b0, s[31:16]};
  endfunction

  function automatic void sum_half(logic [15:0] h);
    csum_acc = fold17({15'd0, fold17({15'd0, csum_acc} + h)});
  endfunction

  function automatic void model_reset();
    foreach (trie_mark[n]) begin
      trie_kid[n][0] = 0;
      trie_kid[n][1] = 0;
      trie_mark[n] = 1'b0;
      trie_hop[n] = '0;
    end
    pool_used = 1;
    my_addr = '0;
    csum_acc = '0;
    hdr_pos = 0;
    hdr_len = 5;
    pkt_dest = '0;
    pkt_ttl = '0;
  endfunction

  function automatic lpm_pkg::status_e trie_insert(logic [31:0] dest, logic [5:0] len_in,
                                                   logic [31:0] hop);
    int unsigned cur;
    int unsigned nx;
    int unsigned len;
    int unsigned b;
    cur = 0;
    len = (len_in > 32) ? 32 : len_in;
    for (int i = 0; i < len; i++) begin
      b = dest[31-i];
      nx = trie_kid[cur][b];
      if (nx == 0) begin
        if (pool_used >= Nodes) return lpm_pkg::ST_TABLE_FULL;
        nx = pool_used;
        pool_used++;
        trie_kid[nx][0] = 0;
        trie_kid[nx][1] = 0;
        trie_mark[nx] = 1'b0;
        trie_hop[nx] = '0;
        trie_kid[cur][b] = nx;
      end
      cur = nx;
    end
    trie_mark[cur] = 1'b1;
    trie_hop[cur] = hop;
    return lpm_pkg::ST_ROUTE_ADD;
  endfunction

  function automatic bit trie_match(logic [31:0] dest, output logic [31:0] hop);
    int unsigned cur;
    int unsigned nx;
    bit found;
    cur = 0;
    found = trie_mark[0];
    hop = trie_hop[0];
    for (int i = 0; i < 32; i++) begin
      nx = trie_kid[cur][dest[31-i]];
      if (nx == 0) break;
      cur = nx;
      if (trie_mark[cur]) begin
        found = 1'b1;
        hop = trie_hop[cur];
      end
    end
    return found;
  endfunction

  // Predicts the result of one accepted beat and queues it when the beat is a route add or ends a header.
  function automatic void lpm_predict(bit rt, logic [31:0] w, logic [31:0] dest,
                                      logic [5:0] len, logic [31:0] hop);
    lpm_pkg::result_t r;
    logic [31:0] found_hop;
    r = '0;
    if (rt == ReqRoute) begin
      r.status = trie_insert(dest, len, hop);
      if (r.status == lpm_pkg::ST_TABLE_FULL) full_seen++;
      fwd_results_q.push_back(r);
      return;
    end
    if (hdr_pos == 0) hdr_len = (w[27:24] < 5) ? 5 : w[27:24];
    if (hdr_pos == 2) begin
      pkt_ttl = w[31:24];
      sum_half({pkt_ttl - 8'd1, w[23:16]});
    end else begin
      sum_half(w[31:16]);
      sum_half(w[15:0]);
    end
    if (hdr_pos == 4) pkt_dest = w;
    if (hdr_pos + 1 < hdr_len) begin
      hdr_pos = (hdr_pos + 1) & 'hF;
      return;
    end
    if (pkt_dest == my_addr) begin
      r.status = lpm_pkg::ST_LOCAL;
    end else if (pkt_ttl == 0) begin
      r.status = lpm_pkg::ST_TTL_DROP;
    end else if (trie_match(pkt_dest, found_hop)) begin
      r.status = lpm_pkg::ST_FORWARD;
      r.next_hop = found_hop;
      r.new_ttl = pkt_ttl - 8'd1;
      r.new_checksum = 16'(~fold17({15'd0, csum_acc}));
      forwards_seen++;
    end else begin
      r.status = lpm_pkg::ST_NO_ROUTE;
    end
    hdr_pos = 0;
    csum_acc = '0;
    fwd_results_q.push_back(r);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
    $display("Mismatch at cycle %0d: %s got 0x%0h, expected 0x%0h",
             cycle_count, what, got, exp);
    err_count++;
  endtask

  // Receiver: stall pattern plus one long hold-off on request.
  initial begin
    int unsigned hold_left;
    int unsigned phase;
    bit          hold_seen;
    hold_left = 0;
    phase = 0;
    hold_seen = 1'b0;
    pop = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 400;
      end
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if ((phase / 300) % 3 == 0) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Result checker; outputs are stable at the falling edge.
  always @(negedge clk_i) begin
    lpm_pkg::result_t e;
    if (rst_ni && pop && !empty) begin
      if (fwd_results_q.size() == 0) begin
        report_mismatch("unexpected beat, status", {29'd0, status_o}, 32'd0);
      end else begin
        e = fwd_results_q.pop_front();
        beats_checked++;
        if (status_o != e.status) report_mismatch("status", status_o, e.status);
        if (next_hop_o != e.next_hop) report_mismatch("next_hop", next_hop_o, e.next_hop);
        if (new_ttl_o != e.new_ttl) report_mismatch("new_ttl", new_ttl_o, e.new_ttl);
        if (new_checksum_o != e.new_checksum)
          report_mismatch("new_checksum", new_checksum_o, e.new_checksum);
      end
    end
  end

  // Sends one beat in bursts with random gaps; returns right after acceptance.
  task automatic send_beat(bit rt, logic [31:0] w, logic [31:0] dest, logic [5:0] len,
                           logic [31:0] hop);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = sender_steady ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    push <= 1'b1;
    req_type_i <= rt;
    header_word_i <= w;
    route_dest_i <= dest;
    route_masklen_i <= len;
    route_nexthop_i <= hop;
    forever begin
      @(negedge clk_i);
      if (!full) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    beats_sent++;
    lpm_predict(rt, w, dest, len, hop);
  endtask

  task automatic send_route(logic [31:0] dest, logic [5:0] len, logic [31:0] hop);
    send_beat(ReqRoute, $urandom, dest, len, hop);
    if (len <= 32 && known_dests.size() < 64) begin
      known_dests.push_back(dest);
      known_lens.push_back(len);
    end
  endtask

  task automatic send_word(logic [31:0] w);
    send_beat(ReqHeader, w, $urandom, 6'($urandom), $urandom);
  endtask

  // Sends a whole header; the destination is word 4.
  task automatic send_packet(logic [3:0] ihl, logic [7:0] ttl, logic [31:0] dest);
    int unsigned words;
    words = (ihl < 5) ? 5 : ihl;
    for (int i = 0; i < words; i++) begin
      case (i)
        0: send_word({4'h4, ihl, 24'($urandom)});
        2: send_word({ttl, 24'($urandom)});
        4: send_word(dest);
        default: send_word($urandom);
      endcase
    end
  endtask

  function automatic logic [31:0] pick_dest();
    logic [31:0] m;
    int unsigned k;
    if (known_dests.size() == 0 || $urandom_range(0, 9) < 2) return $urandom;
    k = $urandom_range(0, known_dests.size() - 1);
    m = (known_lens[k] == 0) ? 32'd0 : (32'hFFFF_FFFF << (32 - known_lens[k]));
    return (known_dests[k] & m) | ($urandom & ~m);
  endfunction

  task automatic wait_drain();
    push <= 1'b0;
    burst_left = 0;
    while (fwd_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_own_addr(logic [31:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    my_addr = v;
  endtask

  // Extremes, every status but table full, short and long IHL, masklen beyond 32.
  task automatic test_directed();
    write_own_addr(32'h0A00_0001);
    send_packet(4'd5, 8'd64, 32'hC0A8_0101);
    send_route(32'h0000_0000, 6'd0, 32'hDEAD_BEEF);
    send_route(32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF);
    send_route(32'h8000_0000, 6'd1, 32'h0000_0000);
    send_route(32'h1234_5678, 6'd63, 32'h1111_2222);
    send_packet(4'd0, 8'd255, 32'hFFFF_FFFF);
    send_packet(4'd15, 8'd1, 32'h8123_4567);
    send_packet(4'd5, 8'd0, 32'h1234_5678);
    send_packet(4'd4, 8'd10, 32'h0A00_0001);
    send_packet(4'd6, 8'd128, 32'h1234_5678);
    // Route add in the middle of a header.
    send_word({4'h4, 4'd5, 24'h00_0054});
    send_word(32'h0000_4000);
    send_route(32'h1234_0000, 6'd16, 32'h0A0A_0A0A);
    send_word({8'd2, 8'd6, 16'hFFFF});
    send_word(32'hFFFF_FFFF);
    send_word(32'h1234_9999);
    wait_drain();
  endtask

  // Several own addresses, the extremes among them.
  task automatic test_own_addr();
    logic [31:0] vals[4];
    vals = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0001, $urandom};
    foreach (vals[i]) begin
      write_own_addr(vals[i]);
      send_packet(4'd5, 8'd9, vals[i]);
      send_packet(4'd5, 8'd9, vals[i] ^ 32'h1);
      send_packet(4'd7, 8'd0, vals[i]);
      wait_drain();
    end
  endtask

  // Long receiver hold-off with the sender still offering beats.
  task automatic test_backpressure();
    hold_req = ~hold_req;
    sender_steady = 1'b1;
    for (int i = 0; i < 30; i++) begin
      if (i % 2 == 0) send_route($urandom, 6'($urandom_range(0, 12)), $urandom);
      else send_packet(4'd5, 8'($urandom_range(1, 255)), pick_dest());
    end
    sender_steady = 1'b0;
    wait_drain();
  endtask

  // Mostly well-formed traffic to known prefixes, some noise.
  task automatic test_random(int unsigned n_beats);
    int unsigned start;
    int unsigned sel;
    start = beats_sent;
    while (beats_sent - start < n_beats) begin
      if ((beats_sent / 150) % 4 == 3) sender_steady = 1'b1;
      else sender_steady = 1'b0;
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
        send_route(pick_dest(), 6'($urandom_range(0, 99) < 90 ? $urandom_range(0, 20)
                                                           : $urandom_range(0, 63)),
                   $urandom);
      end else if (sel < 17) begin
        send_word($urandom);
      end else if (sel < 20) begin
        send_packet(4'($urandom), 8'($urandom), $urandom_range(0, 3) == 0 ? my_addr
                                                                       : pick_dest());
      end else begin
        send_packet(4'($urandom_range(5, 7)), $urandom_range(0, 19) == 0 ? 8'd0
                                                                         : 8'($urandom),
                    pick_dest());
      end
    end
    sender_steady = 1'b0;
    // Finish any partial header so the engine ends at a packet boundary.
    while (hdr_pos != 0) send_word($urandom);
    wait_drain();
  endtask

  // Exhausts the node pool with long prefixes, then checks lookups still work.
  task automatic test_table_full();
    int unsigned extra;
    extra = 0;
    while (extra < 4) begin
      send_route($urandom, 6'd32, $urandom);
      if (pool_used >= Nodes) extra++;
    end
    for (int i = 0; i < 20; i++) send_packet(4'd5, 8'($urandom_range(1, 255)), pick_dest());
    wait_drain();
  endtask

  initial begin
    err_count = 0;
    beats_sent = 0;
    beats_checked = 0;
    forwards_seen = 0;
    full_seen = 0;
    cycle_count = 0;
    burst_left = 0;
    sender_steady = 1'b0;
    hold_req = 1'b0;
    push = 1'b0;
    req_type_i = 1'b0;
    header_word_i = '0;
    route_dest_i = '0;
    route_masklen_i = '0;
    route_nexthop_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    model_reset();
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_own_addr();
    test_backpressure();
    test_random(800);
    write_own_addr($urandom);
    test_random(150);
    test_table_full();

    $display("Sent %0d beats, checked %0d results: %0d forwards, %0d table-full.",
             beats_sent, beats_checked, forwards_seen, full_seen);
    $display("Trie nodes in use at the end: %0d of %0d.", pool_used, Nodes);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", err_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
